/* design/itpa_pkg.sv */
package itpa_pkg;

   localparam int MAX_POINTS_DFLT    = 65536;
   localparam int JACOBI_SWEEPS_DFLT = 8;

   localparam int COORD_W = 24;
   localparam int PROD_W  = 48;
   localparam int SUM_W   = 64;
   localparam int AXIS_W  = 33;
   localparam int NUM_MOM = 6;
   localparam int SCALE_W = 6;

   localparam logic [SUM_W-1:0] SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [63:0]      SCALE_LIMIT = 64'd1 << 27;
   localparam logic [63:0]      Q30_HALF    = 64'd1 << 29;
   localparam logic [63:0]      ONE_Q60     = 64'd1 << 60;
   localparam logic [63:0]      AXIS_MAX    = {31'd0, {AXIS_W{1'b1}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic                      last_point;
   } req_word_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] tensor_xx;
      logic signed [SUM_W-1:0] tensor_xy;
      logic signed [SUM_W-1:0] tensor_xz;
      logic signed [SUM_W-1:0] tensor_yy;
      logic signed [SUM_W-1:0] tensor_yz;
      logic signed [SUM_W-1:0] tensor_zz;
      logic [AXIS_W-1:0]       axis_major;
      logic [AXIS_W-1:0]       axis_middle;
      logic [AXIS_W-1:0]       axis_minor;
      logic                    overflow_flag;
   } rsp_word_type;

   typedef struct packed {
      logic go;
      logic sat;
   } solve_cmd_type;

   typedef enum logic [1:0] {
      CTL_ACCUM,
      CTL_DRAIN,
      CTL_LAUNCH,
      CTL_SOLVE
   } ctl_state_type;

   typedef enum logic [1:0] {
      PIV_01,
      PIV_02,
      PIV_12
   } pivot_type;

   typedef enum logic [4:0] {
      SV_IDLE,
      SV_SCAN,
      SV_SCALE,
      SV_LOAD,
      SV_PIVOT,
      SV_DD,
      SV_EE,
      SV_ROOT_R,
      SV_TAN,
      SV_TT,
      SV_ROOT_Q,
      SV_COS,
      SV_SIN,
      SV_TP,
      SV_CKP,
      SV_SKQ,
      SV_SKP,
      SV_CKQ,
      SV_SORT,
      SV_AXIS,
      SV_DONE
   } slv_state_type;

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] scale_entry(input logic [63:0] v,
                                               input logic [SCALE_W-1:0] s);
      logic [63:0] m;
      m = mag64(v) >> s;
      return v[63] ? (64'd0 - m) : m;
   endfunction

endpackage

/* design/itpa_lane.sv */
module itpa_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                clear,
   input  logic signed [itpa_pkg::COORD_W-1:0] opa,
   input  logic signed [itpa_pkg::COORD_W-1:0] opb,
   output logic signed [itpa_pkg::SUM_W-1:0]   sum,
   output logic                                hit
);
   import itpa_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     vld_ff, vld_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [SUM_W:0]           wide;

   always_comb begin
      prod_in = PROD_W'(opa) * PROD_W'(opb);
      vld_in  = en;
      wide    = {sum_ff[SUM_W-1], sum_ff} + (SUM_W+1)'(prod_ff);
      hit     = 1'b0;
      sum_in  = sum_ff;
      priority if (clear) begin
         sum_in = '0;
      end else if (vld_ff) begin
         // clamp when the carry and sign disagree
         if (wide[SUM_W] != wide[SUM_W-1]) begin
            hit    = 1'b1;
            sum_in = wide[SUM_W] ? SUM_MIN : SUM_MAX;
         end else begin
            sum_in = wide[SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         vld_ff <= 1'b0;
         sum_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

/* design/itpa_mul.sv */
module itpa_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] prod
);
   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in, pp;
   logic [31:0] opx, opy;
   logic [1:0]  step_ff, step_in;
   logic        run_ff, run_in, done_ff, done_in;

   // low 64 bits only: lo*lo, then the two cross terms shifted up
   always_comb begin
      unique case (step_ff)
         2'd0:    begin opx = a_ff[31:0];  opy = b_ff[31:0];  end
         2'd1:    begin opx = a_ff[31:0];  opy = b_ff[63:32]; end
         default: begin opx = a_ff[63:32]; opy = b_ff[31:0];  end
      endcase
      pp      = 64'(opx) * 64'(opy);
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      priority if (go) begin
         a_in    = a;
         b_in    = b;
         step_in = 2'd0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         acc_in  = (step_ff == 2'd0) ? pp : acc_ff + {pp[31:0], 32'd0};
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         step_ff <= 2'd0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

/* design/itpa_div.sv */
module itpa_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);
   logic [63:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [64:0] trial;
   logic        ge;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, num_ff[63]};
      ge      = trial >= {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      priority if (go) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? 64'(trial - {1'b0, den_ff}) : trial[63:0];
         num_in = {num_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

/* design/itpa_sqrt.sv */
module itpa_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] v,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in, rb;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;

   // digit-by-digit integer root, one result bit a cycle
   always_comb begin
      rb      = r_ff + bit_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      priority if (go) begin
         v_in   = v;
         r_in   = '0;
         bit_in = 64'd1 << 62;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (v_ff >= rb) begin
            v_in = v_ff - rb;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

/* design/itpa_solver.sv */
module itpa_solver #(
   parameter int JACOBI_SWEEPS = itpa_pkg::JACOBI_SWEEPS_DFLT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  itpa_pkg::solve_cmd_type          cmd,
   input  logic signed [itpa_pkg::SUM_W-1:0] sums [itpa_pkg::NUM_MOM],
   output logic                             done,
   output itpa_pkg::rsp_word_type           word
);
   import itpa_pkg::*;

   localparam int SWP_W = $clog2(JACOBI_SWEEPS);
   localparam logic [SWP_W-1:0] SWP_LAST = SWP_W'(JACOBI_SWEEPS - 1);

   slv_state_type state_ff, state_in;
   pivot_type     piv_ff, piv_in;
   logic          wait_ff, wait_in;
   logic [SUM_W-1:0] sums_ff [NUM_MOM];
   logic [SUM_W-1:0] sums_in [NUM_MOM];
   logic          sat_ff, sat_in;
   logic [63:0]   maxm_ff, maxm_in;
   logic [SCALE_W-1:0] s_ff, s_in;
   logic [2:0]    idx_ff, idx_in;
   logic [63:0]   a00_ff, a00_in, a01_ff, a01_in, a02_ff, a02_in;
   logic [63:0]   a11_ff, a11_in, a12_ff, a12_in, a22_ff, a22_in;
   logic [SWP_W-1:0] sweep_ff, sweep_in;
   logic [63:0]   ud_ff, ud_in, ue_ff, ue_in, acc_ff, acc_in, den_ff, den_in;
   logic          tneg_ff, tneg_in;
   logic [63:0]   tm_ff, tm_in, t_ff, t_in, c_ff, c_in, sn_ff, sn_in, tp_ff, tp_in;
   logic [63:0]   m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   logic [63:0]   ev_ff [3];
   logic [63:0]   ev_in [3];
   logic [AXIS_W-1:0] ax_ff [3];
   logic [AXIS_W-1:0] ax_in [3];
   logic [1:0]    axi_ff, axi_in;

   // pivot view of the matrix
   logic [63:0] app, aqq, apq, akp, akq, d, e;
   logic [63:0] n_app, n_aqq, n_akp, n_akq;
   // shared units
   logic        mul_go, mul_done, div_go, div_done, sqrt_go, sqrt_done;
   logic [63:0] mul_a, mul_b, mul_prod, div_num, div_den, div_quo, sqrt_v;
   logic [31:0] sqrt_root;
   logic [63:0] qa, qb, qmag, qres;
   logic        unit_done;
   // sort and axis
   logic [63:0] s0, s1, s2, u0, u1, u2, w0, w1;
   logic [4:0]  h, k, hk;
   logic [63:0] m_sel, m_adj, ax_wide;

   itpa_mul u_mul (
      .clock(clock), .reset(reset), .go(mul_go), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_prod)
   );

   itpa_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_quo)
   );

   itpa_sqrt u_sqrt (
      .clock(clock), .reset(reset), .go(sqrt_go), .v(sqrt_v),
      .done(sqrt_done), .root(sqrt_root)
   );

   // pick the pivot entries
   always_comb begin
      unique case (piv_ff)
         PIV_01: begin
            app = a00_ff; aqq = a11_ff; apq = a01_ff; akp = a02_ff; akq = a12_ff;
         end
         PIV_02: begin
            app = a00_ff; aqq = a22_ff; apq = a02_ff; akp = a01_ff; akq = a12_ff;
         end
         default: begin
            app = a11_ff; aqq = a22_ff; apq = a12_ff; akp = a01_ff; akq = a02_ff;
         end
      endcase
      d = aqq - app;
      e = {apq[62:0], 1'b0};
   end

   // operand selection for the shared units
   always_comb begin
      qa    = '0;
      qb    = '0;
      unique case (state_ff)
         SV_SIN:  begin qa = t_ff;  qb = c_ff; end
         SV_TP:   begin qa = t_ff;  qb = apq;  end
         SV_CKP:  begin qa = c_ff;  qb = akp;  end
         SV_SKQ:  begin qa = sn_ff; qb = akq;  end
         SV_SKP:  begin qa = sn_ff; qb = akp;  end
         SV_CKQ:  begin qa = c_ff;  qb = akq;  end
         default: begin qa = '0;    qb = '0;   end
      endcase
      unique case (state_ff)
         SV_DD:   begin mul_a = ud_ff; mul_b = ud_ff; end
         SV_EE:   begin mul_a = ue_ff; mul_b = ue_ff; end
         SV_TT:   begin mul_a = tm_ff; mul_b = tm_ff; end
         default: begin mul_a = mag64(qa); mul_b = mag64(qb); end
      endcase
      qmag = (mul_prod + Q30_HALF) >> 30;
      qres = (qa[63] ^ qb[63]) ? (64'd0 - qmag) : qmag;

      div_den = den_ff;
      div_num = (state_ff == SV_TAN) ? {ue_ff[33:0], 30'd0} + {1'b0, den_ff[63:1]}
                                     : ONE_Q60 + {1'b0, den_ff[63:1]};

      // axis length: fold an odd scale into m, root at most 16 scale bits
      h      = s_ff[SCALE_W-1:1];
      k      = (h > 5'd16) ? 5'd16 : h;
      hk     = h - k;
      m_sel  = ev_ff[axi_ff];
      m_adj  = s_ff[0] ? {m_sel[62:0], 1'b0} : m_sel;
      sqrt_v = (state_ff == SV_AXIS) ? (m_adj << {k, 1'b0}) : acc_ff;
      ax_wide = 64'(sqrt_root) << hk;

      unit_done = 1'b0;
      unique case (state_ff)
         SV_ROOT_R, SV_ROOT_Q, SV_AXIS: unit_done = sqrt_done;
         SV_TAN, SV_COS:                unit_done = div_done;
         default:                       unit_done = mul_done;
      endcase

      n_app = app - tp_ff;
      n_aqq = aqq + tp_ff;
      n_akp = m1_ff - m2_ff;
      n_akq = m3_ff + qres;

      // three compare-exchange steps, ties keep diagonal order
      s0 = mag64(a00_ff);
      s1 = mag64(a11_ff);
      s2 = mag64(a22_ff);
      u0 = (s0 < s1) ? s1 : s0;
      u1 = (s0 < s1) ? s0 : s1;
      u2 = (u1 < s2) ? u1 : s2;
      w1 = (u1 < s2) ? s2 : u1;
      w0 = (u0 < w1) ? w1 : u0;
      s0 = (u0 < w1) ? u0 : w1;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      piv_in   = piv_ff;
      wait_in  = wait_ff;
      sums_in  = sums_ff;
      sat_in   = sat_ff;
      maxm_in  = maxm_ff;
      s_in     = s_ff;
      idx_in   = idx_ff;
      a00_in   = a00_ff; a01_in = a01_ff; a02_in = a02_ff;
      a11_in   = a11_ff; a12_in = a12_ff; a22_in = a22_ff;
      sweep_in = sweep_ff;
      ud_in    = ud_ff;  ue_in = ue_ff; acc_in = acc_ff; den_in = den_ff;
      tneg_in  = tneg_ff;
      tm_in    = tm_ff;  t_in = t_ff; c_in = c_ff; sn_in = sn_ff; tp_in = tp_ff;
      m1_in    = m1_ff;  m2_in = m2_ff; m3_in = m3_ff;
      ev_in    = ev_ff;
      ax_in    = ax_ff;
      axi_in   = axi_ff;
      mul_go   = 1'b0;
      div_go   = 1'b0;
      sqrt_go  = 1'b0;
      done     = 1'b0;

      unique case (state_ff)
         SV_IDLE: begin
            if (cmd.go) begin
               for (int i = 0; i < NUM_MOM; i++) begin
                  sums_in[i] = sums[i];
               end
               sat_in   = cmd.sat;
               maxm_in  = '0;
               idx_in   = '0;
               state_in = SV_SCAN;
            end
         end
         SV_SCAN: begin
            if (mag64(sums_ff[idx_ff]) > maxm_ff) begin
               maxm_in = mag64(sums_ff[idx_ff]);
            end
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'(NUM_MOM - 1)) begin
               s_in     = '0;
               state_in = SV_SCALE;
            end
         end
         SV_SCALE: begin
            if (maxm_ff >= SCALE_LIMIT) begin
               maxm_in = maxm_ff >> 1;
               s_in    = s_ff + 1'b1;
            end else begin
               state_in = SV_LOAD;
            end
         end
         SV_LOAD: begin
            a00_in   = scale_entry(sums_ff[0], s_ff);
            a01_in   = scale_entry(sums_ff[1], s_ff);
            a02_in   = scale_entry(sums_ff[2], s_ff);
            a11_in   = scale_entry(sums_ff[3], s_ff);
            a12_in   = scale_entry(sums_ff[4], s_ff);
            a22_in   = scale_entry(sums_ff[5], s_ff);
            piv_in   = PIV_01;
            sweep_in = '0;
            state_in = SV_PIVOT;
         end
         SV_PIVOT: begin
            if (apq == '0) begin
               state_in = SV_PIVOT;
            end else begin
               ud_in    = mag64(d);
               ue_in    = mag64(e);
               tneg_in  = d[63] ^ e[63];
               state_in = SV_DD;
            end
         end
         SV_SORT: begin
            ev_in[0] = w0;
            ev_in[1] = s0;
            ev_in[2] = u2;
            axi_in   = '0;
            state_in = SV_AXIS;
         end
         SV_DONE: begin
            done     = 1'b1;
            state_in = SV_IDLE;
         end
         default: begin
            // unit-backed steps: launch once, then wait for the unit
            if (!wait_ff) begin
               wait_in = 1'b1;
               unique case (state_ff)
                  SV_ROOT_R, SV_ROOT_Q, SV_AXIS: sqrt_go = 1'b1;
                  SV_TAN, SV_COS:                div_go  = 1'b1;
                  default:                       mul_go  = 1'b1;
               endcase
            end else if (unit_done) begin
               wait_in = 1'b0;
               unique case (state_ff)
                  SV_DD: begin
                     acc_in = mul_prod; state_in = SV_EE;
                  end
                  SV_EE: begin
                     acc_in = acc_ff + mul_prod; state_in = SV_ROOT_R;
                  end
                  SV_ROOT_R: begin
                     den_in = ud_ff + 64'(sqrt_root); state_in = SV_TAN;
                  end
                  SV_TAN: begin
                     tm_in    = div_quo;
                     t_in     = tneg_ff ? (64'd0 - div_quo) : div_quo;
                     state_in = SV_TT;
                  end
                  SV_TT: begin
                     acc_in = mul_prod + ONE_Q60; state_in = SV_ROOT_Q;
                  end
                  SV_ROOT_Q: begin
                     den_in = 64'(sqrt_root); state_in = SV_COS;
                  end
                  SV_COS: begin
                     c_in = div_quo; state_in = SV_SIN;
                  end
                  SV_SIN: begin
                     sn_in = qres; state_in = SV_TP;
                  end
                  SV_TP: begin
                     tp_in = qres; state_in = SV_CKP;
                  end
                  SV_CKP: begin
                     m1_in = qres; state_in = SV_SKQ;
                  end
                  SV_SKQ: begin
                     m2_in = qres; state_in = SV_SKP;
                  end
                  SV_SKP: begin
                     m3_in = qres; state_in = SV_CKQ;
                  end
                  SV_CKQ: begin
                     state_in = SV_PIVOT;
                     unique case (piv_ff)
                        PIV_01: begin
                           a00_in = n_app; a11_in = n_aqq; a01_in = '0;
                           a02_in = n_akp; a12_in = n_akq;
                        end
                        PIV_02: begin
                           a00_in = n_app; a22_in = n_aqq; a02_in = '0;
                           a01_in = n_akp; a12_in = n_akq;
                        end
                        default: begin
                           a11_in = n_app; a22_in = n_aqq; a12_in = '0;
                           a01_in = n_akp; a02_in = n_akq;
                        end
                     endcase
                  end
                  default: begin
                     // axis root
                     ax_in[axi_ff] = (ax_wide > AXIS_MAX) ? AXIS_MAX[AXIS_W-1:0]
                                                          : ax_wide[AXIS_W-1:0];
                     axi_in = axi_ff + 2'd1;
                     state_in = (axi_ff == 2'd2) ? SV_DONE : SV_AXIS;
                  end
               endcase
            end
         end
      endcase

      // advance the pivot after a skipped or finished rotation
      if ((state_ff == SV_PIVOT && apq == '0) ||
          (state_ff == SV_CKQ && wait_ff && unit_done)) begin
         unique case (piv_ff)
            PIV_01: piv_in = PIV_02;
            PIV_02: piv_in = PIV_12;
            default: begin
               piv_in = PIV_01;
               if (sweep_ff == SWP_LAST) begin
                  state_in = SV_SORT;
               end else begin
                  sweep_in = sweep_ff + 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sums_ff  <= sums_in;
      maxm_ff  <= maxm_in;
      s_ff     <= s_in;
      idx_ff   <= idx_in;
      a00_ff   <= a00_in; a01_ff <= a01_in; a02_ff <= a02_in;
      a11_ff   <= a11_in; a12_ff <= a12_in; a22_ff <= a22_in;
      sweep_ff <= sweep_in;
      ud_ff    <= ud_in;  ue_ff <= ue_in; acc_ff <= acc_in; den_ff <= den_in;
      tneg_ff  <= tneg_in;
      tm_ff    <= tm_in;  t_ff <= t_in; c_ff <= c_in; sn_ff <= sn_in; tp_ff <= tp_in;
      m1_ff    <= m1_in;  m2_ff <= m2_in; m3_ff <= m3_in;
      ev_ff    <= ev_in;
      ax_ff    <= ax_in;
      axi_ff   <= axi_in;
      piv_ff   <= piv_in;
      sat_ff   <= sat_in;
      if (reset) begin
         state_ff <= SV_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   always_comb begin
      word.tensor_xx     = sums_ff[0];
      word.tensor_xy     = sums_ff[1];
      word.tensor_xz     = sums_ff[2];
      word.tensor_yy     = sums_ff[3];
      word.tensor_yz     = sums_ff[4];
      word.tensor_zz     = sums_ff[5];
      word.axis_major    = ax_ff[0];
      word.axis_middle   = ax_ff[1];
      word.axis_minor    = ax_ff[2];
      word.overflow_flag = sat_ff;
   end

endmodule

/* design/inertia_tensor_principal_axes.sv */
// Channel   Ports                         Direction  Handshake
// request   start, busy, req_word         in         word taken when start & !busy
// result    rsp_strobe, rsp_word          out        word valid in the strobe cycle
//
// Points: one word per cycle while busy is low; six 24x24 lanes each add in two stages.
// A word with last_point set raises busy through drain, launch and the solve: a scan
// of the six sums, a scale-down, then per non-zero pivot two 64-step divides, two
// 32-step roots and nine 3-step multiplies on shared units, 3 pivots per sweep, then
// the three axis roots; JACOBI_SWEEPS sweeps, eight by default.
// Reset is synchronous and clears sums, count, flag and all sequencers.
// The result receiver has no back-pressure: rsp_strobe lasts one cycle.
module inertia_tensor_principal_axes #(
   parameter int MAX_POINTS    = itpa_pkg::MAX_POINTS_DFLT,
   parameter int JACOBI_SWEEPS = itpa_pkg::JACOBI_SWEEPS_DFLT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  itpa_pkg::req_word_type req_word,
   output logic                   busy,
   output logic                   rsp_strobe,
   output itpa_pkg::rsp_word_type rsp_word
);
   import itpa_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   ctl_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     sat_ff, sat_in;
   logic                     accept, full, take, clear, done;
   logic [NUM_MOM-1:0]       lane_hit;
   logic signed [SUM_W-1:0]  lane_sum [NUM_MOM];
   logic signed [COORD_W-1:0] lane_a [NUM_MOM];
   logic signed [COORD_W-1:0] lane_b [NUM_MOM];
   solve_cmd_type            cmd;

   // lane pairing in order xx xy xz yy yz zz
   assign lane_a[0] = req_word.pos_x; assign lane_b[0] = req_word.pos_x;
   assign lane_a[1] = req_word.pos_x; assign lane_b[1] = req_word.pos_y;
   assign lane_a[2] = req_word.pos_x; assign lane_b[2] = req_word.pos_z;
   assign lane_a[3] = req_word.pos_y; assign lane_b[3] = req_word.pos_y;
   assign lane_a[4] = req_word.pos_y; assign lane_b[4] = req_word.pos_z;
   assign lane_a[5] = req_word.pos_z; assign lane_b[5] = req_word.pos_z;

   for (genvar g = 0; g < NUM_MOM; g++) begin : g_lane
      itpa_lane u_lane (
         .clock (clock),
         .reset (reset),
         .en    (take),
         .clear (clear),
         .opa   (lane_a[g]),
         .opb   (lane_b[g]),
         .sum   (lane_sum[g]),
         .hit   (lane_hit[g])
      );
   end

   // the solver merges the lanes' sums once the set is closed
   itpa_solver #(
      .JACOBI_SWEEPS(JACOBI_SWEEPS)
   ) u_solver (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sums  (lane_sum),
      .done  (done),
      .word  (rsp_word)
   );

   always_comb begin
      busy   = state_ff != CTL_ACCUM;
      accept = start & ~busy;
      full   = count_ff == CNT_W'(MAX_POINTS);
      // drop points past the limit but keep their last mark
      take   = accept & ~full;
      clear  = state_ff == CTL_LAUNCH;
      cmd.go  = clear;
      cmd.sat = sat_ff;

      state_in = state_ff;
      count_in = take ? count_ff + 1'b1 : count_ff;
      sat_in   = sat_ff | (|lane_hit) | (accept & full);

      unique case (state_ff)
         CTL_ACCUM: begin
            if (accept && req_word.last_point) begin
               state_in = CTL_DRAIN;
            end
         end
         // let the last product reach the sums
         CTL_DRAIN: state_in = CTL_LAUNCH;
         CTL_LAUNCH: begin
            // hand the sums over, then clear for the next set
            count_in = '0;
            sat_in   = 1'b0;
            state_in = CTL_SOLVE;
         end
         CTL_SOLVE: begin
            if (done) begin
               state_in = CTL_ACCUM;
            end
         end
         default: state_in = CTL_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_ACCUM;
         count_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_strobe = done;

endmodule
